>>> hw/rtl/mrc_pkg.sv
// Shared types and constants for the Modbus RTU response checker.
// Used by mrc_frame_tracker, modbus_response_checker and the testbench; depends on nothing.
package mrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;
    localparam logic [9:0]  POS_MAX  = 10'd1023;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EXCEPTION  = 2'd1,
        STAT_CRC_BAD    = 2'd2,
        STAT_BAD_LENGTH = 2'd3
    } status_t;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] reg_word;
        logic [6:0]  reg_index;
        status_t     frame_status;
        logic [7:0]  exception_code;
        logic        is_last;
    } result_t;

endpackage

>>> hw/rtl/modbus_response_checker.sv
// Top level of the Modbus RTU response checker: input request register,
// frame tracker and result register. Depends on mrc_pkg and mrc_frame_tracker.
//
// Feed the response bytes in order, one request each, with frame_end set on
// the last byte. Every register word is reported as soon as its second byte
// arrives; words are provisional until the single status result that closes
// the frame. The block takes one byte per cycle while the result side does
// not stall; a byte passes the input register, the CRC and frame logic and
// then the result register, which also decouples the two sides so a new
// byte is accepted while a result waits to be taken.
module modbus_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        item_kind,
    output logic [15:0] reg_word,
    output logic [6:0]  reg_index,
    output logic [1:0]  frame_status,
    output logic [7:0]  exception_code,
    output logic        is_last
);
    import mrc_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;

    logic       out_free;
    logic       s1_go;
    logic       accept;
    logic       res_valid;
    result_t    res;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_go      = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;

    mrc_frame_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_go),
        .rx_byte   (s1_byte_reg),
        .frame_end (s1_end_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_go && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_end_reg  <= frame_end;
        end
        if (s1_go && res_valid)
            out_res_reg <= res;
    end

    assign result_valid   = out_valid_reg;
    assign item_kind      = out_res_reg.item_kind;
    assign reg_word       = out_res_reg.reg_word;
    assign reg_index      = out_res_reg.reg_index;
    assign frame_status   = out_res_reg.frame_status;
    assign exception_code = out_res_reg.exception_code;
    assign is_last        = out_res_reg.is_last;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("input stalled while the result side is free");

    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && item_kind == KIND_WORD |->
            !is_last && frame_status == STAT_OK && exception_code == 8'd0)
        else $error("word result carries status fields");

    a_code_only_on_exception: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_status != STAT_EXCEPTION |-> exception_code == 8'd0)
        else $error("exception code set without an exception status");
`endif

endmodule

>>> hw/rtl/mrc_frame_tracker.sv
// Per-frame state of the response checker: CRC, byte position, header bytes
// and word assembly. Produces at most one result for each processed byte.
// Depends on mrc_pkg.
module mrc_frame_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    input  logic            frame_end,
    output logic            res_valid,
    output mrc_pkg::result_t res
);
    import mrc_pkg::*;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic [15:0] crc_reg, crc_next;
    logic [9:0]  pos_reg, pos_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  high_reg, high_next;
    logic [6:0]  word_index_reg, word_index_next;

    logic [7:0]  older;
    logic [7:0]  newer;
    logic [15:0] crc_upd;
    logic [7:0]  func_cur;
    logic [7:0]  count_cur;
    logic        in_data;
    logic        is_exc;
    logic        is_crc_bad;
    logic        is_short;

    assign older     = delay_reg[15:8];
    assign newer     = delay_reg[7:0];
    assign crc_upd   = (pos_reg >= 10'd2) ? crc_feed(crc_reg, older) : crc_reg;
    assign func_cur  = (pos_reg == 10'd1) ? rx_byte : func_reg;
    assign count_cur = (pos_reg == 10'd2) ? rx_byte : count_reg;
    assign in_data   = (pos_reg >= 10'd3) && (pos_reg <= ({2'd0, count_reg} + 10'd2));

    assign is_exc     = (pos_reg >= 10'd2) && (func_cur >= EXC_FLAG);
    assign is_crc_bad = (pos_reg < 10'd3) || (crc_upd != {rx_byte, newer});
    assign is_short   = {1'b0, pos_reg} < ({3'd0, count_cur} + 11'd4);

    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (frame_end)
        begin
            res_valid     = step;
            res.item_kind = KIND_STATUS;
            res.is_last   = 1'b1;
            if (is_exc)
            begin
                res.frame_status   = STAT_EXCEPTION;
                res.exception_code = count_cur;
            end
            else if (is_crc_bad)
                res.frame_status = STAT_CRC_BAD;
            else if (is_short)
                res.frame_status = STAT_BAD_LENGTH;
            else
                res.frame_status = STAT_OK;
        end
        else if (in_data && !pos_reg[0])
        begin
            res_valid     = step;
            res.item_kind = KIND_WORD;
            res.reg_word  = {high_reg, rx_byte};
            res.reg_index = word_index_reg;
        end
    end

    always_comb
    begin
        crc_next        = crc_reg;
        pos_next        = pos_reg;
        delay_next      = delay_reg;
        func_next       = func_reg;
        count_next      = count_reg;
        high_next       = high_reg;
        word_index_next = word_index_reg;
        if (step)
        begin
            if (frame_end)
            begin
                crc_next        = CRC_INIT;
                pos_next        = '0;
                delay_next      = '0;
                func_next       = '0;
                count_next      = '0;
                high_next       = '0;
                word_index_next = '0;
            end
            else
            begin
                crc_next   = crc_upd;
                func_next  = func_cur;
                count_next = count_cur;
                delay_next = {newer, rx_byte};
                if (pos_reg < POS_MAX)
                    pos_next = pos_reg + 10'd1;
                if (in_data && pos_reg[0])
                    high_next = rx_byte;
                if (in_data && !pos_reg[0])
                    word_index_next = word_index_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            pos_reg        <= '0;
            delay_reg      <= '0;
            func_reg       <= '0;
            count_reg      <= '0;
            high_reg       <= '0;
            word_index_reg <= '0;
        end
        else
        begin
            crc_reg        <= crc_next;
            pos_reg        <= pos_next;
            delay_reg      <= delay_next;
            func_reg       <= func_next;
            count_reg      <= count_next;
            high_reg       <= high_next;
            word_index_reg <= word_index_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_end |=> pos_reg == 10'd0 && word_index_reg == 7'd0 && crc_reg == CRC_INIT)
        else $error("frame state not cleared after frame end");

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step)
        else $error("result raised without a processed byte");

    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && !frame_end && res_valid |=>
            word_index_reg == 7'($past(word_index_reg) + 7'd1))
        else $error("word index did not advance after a word");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for modbus_response_checker: directed frames, then random
// response frames with bursty byte traffic and a stalling result side.
// Depends on mrc_pkg and the modbus_response_checker RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_CRC_LO,
        SRC_CRC_HI
    } byte_src_t;

    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_TOGGLE
    } drain_mode_t;

    typedef struct packed {
        byte_src_t src;
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_ITEM = '0;
    localparam int RANDOM_BYTES = 1900;
    localparam int OVERSIZE_AT = 900;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        item_kind;
    logic [15:0] reg_word;
    logic [6:0]  reg_index;
    logic [1:0]  frame_status;
    logic [7:0]  exception_code;
    logic        is_last;

    result_t    items_due[$];
    logic [7:0] frame_bytes[$];
    int         bytes_sent = 0;
    int         frames_sent = 0;
    int         results_seen = 0;
    int         fault_count = 0;
    int         burst_left = 0;
    int         stat_seen[4] = '{0, 0, 0, 0};
    bit         long_done = 1'b0;

    logic [15:0] crc_run = CRC_INIT;
    logic [9:0]  pos_count = '0;
    logic [15:0] held_pair = '0;
    logic [7:0]  fn_code = '0;
    logic [7:0]  byte_count = '0;
    logic [7:0]  hi_byte = '0;
    logic [6:0]  next_index = '0;

    dir_row_t dir_rows [27] = '{
        '{SRC_DATA,   8'h00, 1'b1, 1'b1, {KIND_STATUS, 16'h0000, 7'd0, STAT_CRC_BAD, 8'h00, 1'b1}},
        '{SRC_DATA,   8'hFF, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hFF, 1'b1, 1'b1, {KIND_STATUS, 16'h0000, 7'd0, STAT_CRC_BAD, 8'h00, 1'b1}},
        '{SRC_DATA,   8'h11, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h83, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h02, 1'b1, 1'b1,
            {KIND_STATUS, 16'h0000, 7'd0, STAT_EXCEPTION, 8'h02, 1'b1}},
        '{SRC_DATA,   8'h01, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h03, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h04, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h00, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h00, 1'b0, 1'b1, {KIND_WORD, 16'h0000, 7'd0, STAT_OK, 8'h00, 1'b0}},
        '{SRC_DATA,   8'hFF, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hFF, 1'b0, 1'b1, {KIND_WORD, 16'hFFFF, 7'd1, STAT_OK, 8'h00, 1'b0}},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_ITEM},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b1, {KIND_STATUS, 16'h0000, 7'd0, STAT_OK, 8'h00, 1'b1}},
        '{SRC_DATA,   8'h01, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h03, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h10, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hBB, 1'b0, 1'b1, {KIND_WORD, 16'hAABB, 7'd0, STAT_OK, 8'h00, 1'b0}},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_ITEM},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b1,
            {KIND_STATUS, 16'h0000, 7'd0, STAT_BAD_LENGTH, 8'h00, 1'b1}},
        '{SRC_DATA,   8'h01, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h03, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'h02, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hAB, 1'b0, 1'b0, NO_ITEM},
        '{SRC_DATA,   8'hCD, 1'b1, 1'b0, NO_ITEM}
    };

    modbus_response_checker DUT (.*);

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", items_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        crc ^= {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // The CRC trails the input by two bytes, so the last two bytes of a frame
    // are compared against it instead of being folded in.
    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output logic emits, output result_t item);
        int         p;
        int         len;
        logic [7:0] older;
        logic [7:0] newer;
        p = int'(pos_count);
        older = held_pair[15:8];
        newer = held_pair[7:0];
        emits = 1'b0;
        item = NO_ITEM;
        if (p >= 2)
            crc_run = crc16_byte(crc_run, older);
        if (p == 1)
            fn_code = b;
        if (p == 2)
            byte_count = b;
        if (last)
        begin
            len = p + 1;
            emits = 1'b1;
            item.item_kind = KIND_STATUS;
            item.is_last = 1'b1;
            if (len >= 3 && fn_code >= EXC_FLAG)
            begin
                item.frame_status = STAT_EXCEPTION;
                item.exception_code = byte_count;
            end
            else if (len < 4 || crc_run != {b, newer})
                item.frame_status = STAT_CRC_BAD;
            else if (len < int'(byte_count) + 5)
                item.frame_status = STAT_BAD_LENGTH;
            else
                item.frame_status = STAT_OK;
            crc_run = CRC_INIT;
            pos_count = '0;
            held_pair = '0;
            fn_code = '0;
            byte_count = '0;
            hi_byte = '0;
            next_index = '0;
        end
        else
        begin
            held_pair = {newer, b};
            if (pos_count < POS_MAX)
                pos_count++;
            if (p >= 3 && p <= 2 + int'(byte_count))
            begin
                if (((p - 3) & 1) == 0)
                    hi_byte = b;
                else
                begin
                    emits = 1'b1;
                    item.item_kind = KIND_WORD;
                    item.reg_word = {hi_byte, b};
                    item.reg_index = next_index;
                    next_index++;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input result_t want);
        int      gap;
        logic    emits;
        result_t item;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= last;
        do
            @(posedge clk);
        while (byte_stall);
        burst_left--;
        bytes_sent++;
        decode_byte(b, last, emits, item);
        if (typed)
            items_due = {items_due, want};
        else if (emits)
            items_due = {items_due, item};
        if (last)
            frames_sent++;
    endtask

    // Most frames are well formed, random or exception responses; the rest carry a
    // flipped bit, a length that may not match the byte count, or are plain noise.
    task automatic build_frame(input bit oversize);
        int          pick;
        int          n;
        int          at;
        logic [7:0]  cnt;
        logic [15:0] crc;
        frame_bytes.delete();
        pick = oversize ? 0 : $urandom_range(0, 99);
        if (pick < 88)
        begin
            frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            if (pick >= 60 && pick < 70)
            begin
                frame_bytes = {frame_bytes, 8'($urandom_range(128, 255))};
                frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            end
            else
            begin
                if (oversize)
                    cnt = 8'hFF;
                else if ($urandom_range(0, 19) == 0)
                    cnt = 8'($urandom_range(13, 255));
                else
                    cnt = 8'($urandom_range(0, 12));
                frame_bytes = {frame_bytes, 8'($urandom_range(0, 127))};
                frame_bytes = {frame_bytes, cnt};
                if (oversize)
                    n = 1025;
                else if (pick >= 80)
                    n = $urandom_range(0, int'(cnt) + 4);
                else
                    n = cnt;
                repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            end
            crc = CRC_INIT;
            foreach (frame_bytes[i])
                crc = crc16_byte(crc, frame_bytes[i]);
            frame_bytes = {frame_bytes, crc[7:0]};
            frame_bytes = {frame_bytes, crc[15:8]};
            if (pick >= 70 && pick < 80)
            begin
                at = $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[at] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        else
        begin
            n = (pick < 96) ? $urandom_range(1, 4) : $urandom_range(1, 24);
            repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
        end
    endtask

    task automatic report_fault(input string what, input result_t want, input result_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t %s: expected kind=%0d word=%h index=%0d status=%0d code=%h last=%0d",
                     $time, what, want.item_kind, want.reg_word, want.reg_index,
                     want.frame_status, want.exception_code, want.is_last);
            $display("    got kind=%0d word=%h index=%0d status=%0d code=%h last=%0d",
                     got.item_kind, got.reg_word, got.reg_index, got.frame_status,
                     got.exception_code, got.is_last);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {item_kind, reg_word, reg_index, frame_status, exception_code, is_last};
            results_seen++;
            if (got.item_kind == KIND_STATUS)
                stat_seen[got.frame_status]++;
            if (items_due.size() == 0)
                report_fault("result with nothing expected", NO_ITEM, got);
            else
            begin
                want = items_due.pop_front();
                if (got !== want)
                    report_fault("result mismatch", want, got);
            end
        end
    end

    // Result side: phases of different stall densities, plus long hold-offs
    // while requests keep arriving so that the block backs up into its input.
    initial
    begin
        drain_mode_t mode;
        int          span;
        int          hold_mark;
        hold_mark = 400;
        @(posedge rst_n);
        forever
        begin
            if (bytes_sent >= hold_mark)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_mark += 1000;
            end
            mode = drain_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 120);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    DRAIN_FREE:   result_stall <= 1'b0;
                    DRAIN_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
                    DRAIN_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
                    default:      result_stall <= ~result_stall;
                endcase
            end
        end
    end

    initial
    begin
        logic [7:0]  b;
        logic [15:0] walk_crc;
        bit          big;
        walk_crc = CRC_INIT;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].src)
                SRC_CRC_LO: b = walk_crc[7:0];
                SRC_CRC_HI: b = walk_crc[15:8];
                default:
                begin
                    b = dir_rows[i].data;
                    walk_crc = crc16_byte(walk_crc, b);
                end
            endcase
            send_byte(b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
            if (dir_rows[i].last)
                walk_crc = CRC_INIT;
        end

        while (bytes_sent < RANDOM_BYTES)
        begin
            big = !long_done && bytes_sent >= OVERSIZE_AT;
            long_done |= big;
            build_frame(big);
            for (int i = 0; i < frame_bytes.size(); i++)
                send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_ITEM);
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (items_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d frames (%0d bytes, one beyond the position limit), %0d results.",
                 frames_sent, bytes_sent, results_seen);
        $display("Frame status seen: %0d ok, %0d exception, %0d crc or short, %0d bad length.",
                 stat_seen[STAT_OK], stat_seen[STAT_EXCEPTION], stat_seen[STAT_CRC_BAD],
                 stat_seen[STAT_BAD_LENGTH]);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d faulty results.", fault_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_frame_tracker.sv
hw/rtl/modbus_response_checker.sv
tb/sv/testbench.sv
